// ----- rtl/core/swks_pkg.sv -----
`default_nettype none

package swks_pkg;

    // default sizing
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // configuration registers
    localparam int CFG_BITS   = 7;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam int REG_SEL_LO = 2;

    localparam logic [CFG_BITS-1:0] WINDOW_LEN_RST = CFG_BITS'(8);
    localparam logic [CFG_BITS-1:0] K_COUNT_RST    = CFG_BITS'(4);

    typedef enum logic [0:0] {
        REG_WINDOW_LEN = 1'b0,
        REG_K_COUNT    = 1'b1
    } reg_sel_t;

    // flags a cell hands to its neighbors
    typedef struct packed {
        logic ge_rem;      // holds a valid value at or above the leaving word
        logic move_left;   // own value shifts one cell toward the head
        logic move_right;  // own value shifts one cell toward the tail
    } link_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic upd;         // rebuild the sorted row this cycle
        logic rem;         // window full, oldest word leaves
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/swks_ram.sv -----
`default_nettype none

module swks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/swks_cell.sv -----
`default_nettype none

module swks_cell #(
    parameter int INDEX       = 0,
    parameter int SAMPLE_BITS = 32,
    parameter int SUM_BITS    = 38,
    parameter int LEN_BITS    = 7
) (
    input  wire logic                     clk,
    input  wire swks_pkg::cell_ctl_t      ctl,
    input  wire logic [LEN_BITS-1:0]      fill,
    input  wire logic [LEN_BITS-1:0]      k_eff,
    input  wire logic [SAMPLE_BITS-1:0]   ins_val,
    input  wire logic [SAMPLE_BITS-1:0]   rem_val,
    input  wire swks_pkg::link_t          left_link,
    input  wire logic [SAMPLE_BITS-1:0]   left_val,
    input  wire swks_pkg::link_t          right_link,
    input  wire logic [SAMPLE_BITS-1:0]   right_val,
    input  wire logic [SUM_BITS-1:0]      right_acc,
    output swks_pkg::link_t               link,
    output logic      [SAMPLE_BITS-1:0]   val,
    output logic      [SUM_BITS-1:0]      acc
);

    localparam logic [LEN_BITS-1:0] MY_IDX = LEN_BITS'(INDEX);

    logic [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [SUM_BITS-1:0]    acc_reg, acc_next;
    logic                   valid;
    logic                   is_rem;
    logic                   after_rem;
    logic                   before_rem;
    logic                   le_ins;
    logic                   stay;

    // position relative to the leaving word and the new word
    always_comb
    begin
        valid       = MY_IDX < fill;
        link.ge_rem = ctl.rem && valid && (val_reg >= rem_val);
        is_rem      = link.ge_rem && !left_link.ge_rem;
        after_rem   = link.ge_rem && !is_rem;
        before_rem  = valid && !link.ge_rem;
        le_ins      = val_reg <= ins_val;

        stay            = (after_rem && !le_ins) || (before_rem && le_ins);
        link.move_left  = after_rem && le_ins;
        link.move_right = before_rem && !le_ins;
    end

    // pick own value, a neighbor's, or the new word
    always_comb
    begin
        val_next = val_reg;
        if (ctl.upd)
        begin
            if (stay)
            begin
                val_next = val_reg;
            end
            else if (left_link.move_right)
            begin
                val_next = left_val;
            end
            else if (right_link.move_left)
            begin
                val_next = right_val;
            end
            else
            begin
                val_next = ins_val;
            end
        end
    end

    // partial sum wave moving toward the head
    always_comb
    begin
        if (ctl.upd)
        begin
            acc_next = '0;
        end
        else if (MY_IDX < k_eff)
        begin
            acc_next = right_acc + SUM_BITS'(val_reg);
        end
        else
        begin
            acc_next = right_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        acc_reg <= acc_next;
    end

    assign val = val_reg;
    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sliding_window_k_smallest_sum.sv -----
`default_nettype none

// channel   direction  handshake            payload
// in        to block   in_valid/in_ready    sample
// out       from block out_valid/out_ready  window_sum
// cfg       to block   psel/penable/pready  paddr, pwdata, prdata
//
// an item is taken in ST_IDLE while the leaving word is fetched from the
// arrival ring; ST_UPD rebuilds the sorted cell row, and once the window is
// full (k being the clamped k_count) ST_SUM lets a partial sum walk one cell
// per cycle from cell k-1 to cell 0.
// reset empties the window; the next word is taken while a result waits,
// but a new result holds off until the waiting one is taken.

module sliding_window_k_smallest_sum #(
    parameter int WINDOW_MAX  = swks_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swks_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_MAX)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [SAMPLE_BITS-1:0]             sample,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [SUM_BITS-1:0]                window_sum,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [swks_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [swks_pkg::DATA_BITS-1:0]     pwdata,
    output logic      [swks_pkg::DATA_BITS-1:0]     prdata,
    output logic                                    pready
);

    localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int HEAD_BITS = $clog2(WINDOW_MAX);
    localparam int CMP_BITS  = (LEN_BITS > swks_pkg::CFG_BITS) ? LEN_BITS
                                                               : swks_pkg::CFG_BITS;
    localparam logic [CMP_BITS-1:0] MAX_CMP = CMP_BITS'(WINDOW_MAX);
    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(WINDOW_MAX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_SUM
    } state_t;

    state_t                          state_reg, state_next;
    logic [swks_pkg::CFG_BITS-1:0]   window_len_reg, window_len_next;
    logic [swks_pkg::CFG_BITS-1:0]   k_count_reg, k_count_next;
    logic [HEAD_BITS-1:0]            head_reg, head_next;
    logic [LEN_BITS-1:0]             fill_reg, fill_next;
    logic [LEN_BITS-1:0]             sum_cnt_reg, sum_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0]             out_data_reg, out_data_next;
    logic [SAMPLE_BITS-1:0]          word_reg, word_next;

    logic [CMP_BITS-1:0]             wl_ext;
    logic [CMP_BITS-1:0]             kc_ext;
    logic [LEN_BITS-1:0]             len_eff;
    logic [LEN_BITS-1:0]             k_eff;
    logic                            cfg_wr;
    swks_pkg::reg_sel_t              reg_sel;
    logic [SAMPLE_BITS-1:0]          rem_word;
    logic                            ring_we;
    logic                            head_wrap;
    logic [LEN_BITS-1:0]             fill_upd;
    swks_pkg::cell_ctl_t             ctl;

    swks_pkg::link_t                 cell_link [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0]          cell_val  [WINDOW_MAX];
    logic [SUM_BITS-1:0]             cell_acc  [WINDOW_MAX];

    // register decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = swks_pkg::reg_sel_t'(paddr[swks_pkg::REG_SEL_LO]);

    always_comb
    begin
        unique case (reg_sel)
            swks_pkg::REG_WINDOW_LEN:
            begin
                prdata = swks_pkg::DATA_BITS'(window_len_reg);
            end
            swks_pkg::REG_K_COUNT:
            begin
                prdata = swks_pkg::DATA_BITS'(k_count_reg);
            end
        endcase
    end

    // clamp window length and count
    always_comb
    begin
        wl_ext = CMP_BITS'(window_len_reg);
        kc_ext = CMP_BITS'(k_count_reg);
        if (wl_ext == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (wl_ext > MAX_CMP)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = LEN_BITS'(wl_ext);
        end

        if (kc_ext == '0)
        begin
            k_eff = LEN_BITS'(1);
        end
        else if (kc_ext > CMP_BITS'(len_eff))
        begin
            k_eff = len_eff;
        end
        else
        begin
            k_eff = LEN_BITS'(kc_ext);
        end
    end

    // arrival ring
    swks_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (head_reg),
        .wdata (word_reg),
        .raddr (head_reg),
        .rdata (rem_word)
    );

    assign ring_we   = (state_reg == ST_UPD);
    assign ctl.upd   = (state_reg == ST_UPD);
    assign ctl.rem   = (fill_reg == len_eff);
    assign head_wrap = (LEN_BITS'(head_reg) + LEN_BITS'(1)) == len_eff;
    assign fill_upd  = ctl.rem ? fill_reg : fill_reg + LEN_BITS'(1);

    // sorted cell row
    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        swks_pkg::link_t        l_link;
        logic [SAMPLE_BITS-1:0] l_val;
        swks_pkg::link_t        r_link;
        logic [SAMPLE_BITS-1:0] r_val;
        logic [SUM_BITS-1:0]    r_acc;

        if (g == 0)
        begin : g_head
            assign l_link = '0;
            assign l_val  = '0;
        end
        else
        begin : g_mid_l
            assign l_link = cell_link[g-1];
            assign l_val  = cell_val[g-1];
        end

        if (g == WINDOW_MAX - 1)
        begin : g_tail
            assign r_link = '0;
            assign r_val  = '0;
            assign r_acc  = '0;
        end
        else
        begin : g_mid_r
            assign r_link = cell_link[g+1];
            assign r_val  = cell_val[g+1];
            assign r_acc  = cell_acc[g+1];
        end

        swks_cell #(
            .INDEX       (g),
            .SAMPLE_BITS (SAMPLE_BITS),
            .SUM_BITS    (SUM_BITS),
            .LEN_BITS    (LEN_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .fill       (fill_reg),
            .k_eff      (k_eff),
            .ins_val    (word_reg),
            .rem_val    (rem_word),
            .left_link  (l_link),
            .left_val   (l_val),
            .right_link (r_link),
            .right_val  (r_val),
            .right_acc  (r_acc),
            .link       (cell_link[g]),
            .val        (cell_val[g]),
            .acc        (cell_acc[g])
        );
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        window_len_next = window_len_reg;
        k_count_next    = k_count_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        sum_cnt_next    = sum_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        word_next       = word_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = sample;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                head_next    = head_wrap ? '0 : head_reg + HEAD_BITS'(1);
                fill_next    = fill_upd;
                sum_cnt_next = k_eff;
                state_next   = (fill_upd == len_eff) ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                if (sum_cnt_reg != '0)
                begin
                    sum_cnt_next = sum_cnt_reg - LEN_BITS'(1);
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = cell_acc[0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write empties the window
        if (cfg_wr)
        begin
            unique case (reg_sel)
                swks_pkg::REG_WINDOW_LEN:
                begin
                    window_len_next = pwdata[swks_pkg::CFG_BITS-1:0];
                end
                swks_pkg::REG_K_COUNT:
                begin
                    k_count_next = pwdata[swks_pkg::CFG_BITS-1:0];
                end
            endcase
            head_next = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= swks_pkg::WINDOW_LEN_RST;
            k_count_reg    <= swks_pkg::K_COUNT_RST;
            head_reg       <= '0;
            fill_reg       <= '0;
            sum_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            k_count_reg    <= k_count_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            sum_cnt_reg    <= sum_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        word_reg     <= word_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign window_sum = out_data_reg;

endmodule

`default_nettype wire
